FILE: hw/rtl/dcsa_pkg.sv
// Package with shared widths, register codes, data types and the sine and exponential tables.
package dcsa_pkg;

    localparam int PHASE_TABLE_BITS = 10;
    localparam int EXP_TABLE_BITS   = 8;
    localparam int POSITION_BITS    = 16;

    localparam int SAMPLE_POSITION_W = 16;
    localparam int SAMPLE_W          = 32;
    localparam int AMPLITUDE_W       = 16;
    localparam int PHASE_W           = 32;
    localparam int DECAY_W           = 32;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_INDEX_W       = 2;
    localparam int Q15_W             = 15;
    localparam int FRAC_BITS         = 16;
    localparam int SHIFT_W           = 4;
    localparam int PIPE_STAGES       = 5;

    localparam int POS_W = (POSITION_BITS < SAMPLE_POSITION_W) ? POSITION_BITS
                                                                 : SAMPLE_POSITION_W;
    localparam int X_W          = POS_W + DECAY_W;
    localparam int QUARTER      = 1 << (PHASE_TABLE_BITS - 2);
    localparam int SINE_ENTRIES = QUARTER + 1;
    localparam int SINE_IDX_W   = PHASE_TABLE_BITS - 1;
    localparam int EXP_ENTRIES  = 1 << EXP_TABLE_BITS;
    localparam int AMP_ENV_W    = AMPLITUDE_W + Q15_W;
    localparam int PROD_W       = AMP_ENV_W + Q15_W + 1;
    localparam int MAG_W        = PROD_W - 30;
    localparam int SUM_W        = SAMPLE_W + 2;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_LN2     = 64'd744261118;
    localparam logic [63:0] Q15_MAX     = 64'd32767;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_AMPLITUDE  = 2'd0,
        CFG_PHASE_STEP = 2'd1,
        CFG_DECAY_LOG2 = 2'd2,
        CFG_ADD_MODE   = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_FOURTH = 2'd3
    } t_quad;

    typedef struct packed {
        logic [AMPLITUDE_W-1:0] amplitude;
        logic [PHASE_W-1:0]     phase_step;
        logic [DECAY_W-1:0]     decay_log2;
        logic                   add_mode;
    } t_cfg;

    typedef struct packed {
        logic [Q15_W-1:0] cmag;
        logic [Q15_W-1:0] smag;
        logic             cneg;
        logic             sneg;
    } t_trig;

    typedef logic [SINE_ENTRIES-1:0][Q15_W-1:0] t_sine_rom;
    typedef logic [EXP_ENTRIES-1:0][Q15_W-1:0]  t_exp_rom;

    function automatic logic [Q15_W-1:0] q30_to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd16384) >> 15;
        return (r > Q15_MAX) ? Q15_W'(Q15_MAX) : r[Q15_W-1:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        for (int j = 0; j < SINE_ENTRIES; j++) begin
            x    = (64'(j) * Q30_HALF_PI) >> (PHASE_TABLE_BITS - 2);
            term = x;
            sum  = x;
            for (int k = 1; k <= 6; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k[0]) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            rom[j] = q30_to_q15(sum);
        end
        return rom;
    endfunction

    function automatic t_exp_rom build_exp_rom();
        t_exp_rom    rom;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        for (int f = 0; f < EXP_ENTRIES; f++) begin
            y    = (64'(f) * Q30_LN2) >> EXP_TABLE_BITS;
            term = Q30_ONE;
            sum  = Q30_ONE;
            for (int k = 1; k <= 12; k++) begin
                term = ((term * y) >> 30) / 64'(k);
                if (k[0]) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            rom[f] = q30_to_q15(sum);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();
    localparam t_exp_rom  EXP_ROM  = build_exp_rom();

endpackage

FILE: hw/rtl/damped_complex_sinusoid_adder.sv
// Top level of the damped complex sinusoid adder with its five-stage datapath.
//
// The input channel (i_valid, o_ready) carries a sample position and an existing
// complex sample. The output channel (o_valid, i_ready) returns the new complex
// sample, either the generated damped sinusoid added to the input or the
// generated value alone, saturated to 32 bits in each component.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data; the user
// must write it only while the block is idle, since the block does not enforce
// this. A write takes effect at the next clock edge. The datapath has five
// register stages: position multiplies, table lookups and envelope shift,
// amplitude scaling, trig scaling with rounding, then sign, add and saturation
// into the output register. One item is accepted every cycle while the output
// side keeps up.
// Each stage advances whenever it is empty or the stage after it advances, so a
// stall on i_ready fills the bubbles first and then holds every item in place;
// nothing is dropped or repeated. Up to five items can be in flight.
// Reset clears all valid bits and the configuration registers to zero.
module damped_complex_sinusoid_adder (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [dcsa_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [dcsa_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [dcsa_pkg::SAMPLE_POSITION_W-1:0] i_sample_position,
    input  logic signed [dcsa_pkg::SAMPLE_W-1:0]   i_real_in,
    input  logic signed [dcsa_pkg::SAMPLE_W-1:0]   i_imag_in,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [dcsa_pkg::SAMPLE_W-1:0]   o_real_out,
    output logic signed [dcsa_pkg::SAMPLE_W-1:0]   o_imag_out
);
    import dcsa_pkg::*;

    t_cfg cfg;

    dcsa_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    logic [PIPE_STAGES:1] r_v;
    logic [PIPE_STAGES:1] stage_en;

    always_comb begin
        stage_en[PIPE_STAGES] = !r_v[PIPE_STAGES] || i_ready;
        for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
    end

    assign o_ready = stage_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= PIPE_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: phase and envelope exponent.
    logic [POS_W-1:0]            n_pos;
    logic [PHASE_W-1:0]          n_phase;
    logic [X_W-1:0]              n_x;
    logic [PHASE_TABLE_BITS-1:0] r_s1_phase;
    logic [EXP_TABLE_BITS-1:0]   r_s1_frac;
    logic [SHIFT_W-1:0]          r_s1_shift;
    logic                        r_s1_zero;
    logic signed [SAMPLE_W-1:0]  r_s1_re;
    logic signed [SAMPLE_W-1:0]  r_s1_im;

    assign n_pos   = i_sample_position[POS_W-1:0];
    assign n_phase = PHASE_W'(PHASE_W'(n_pos) * cfg.phase_step);
    assign n_x     = X_W'(X_W'(n_pos) * X_W'(cfg.decay_log2));

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_s1_phase <= n_phase[PHASE_W-1 -: PHASE_TABLE_BITS];
            r_s1_frac  <= n_x[FRAC_BITS-1 -: EXP_TABLE_BITS];
            r_s1_shift <= n_x[FRAC_BITS +: SHIFT_W];
            r_s1_zero  <= |n_x[X_W-1:FRAC_BITS+SHIFT_W];
            r_s1_re    <= i_real_in;
            r_s1_im    <= i_imag_in;
        end
    end

    // Stage 2: table lookups and envelope shift.
    t_trig                      n_trig;
    logic [Q15_W-1:0]           n_env;
    t_trig                      r_s2_trig;
    logic [Q15_W-1:0]           r_s2_env;
    logic signed [SAMPLE_W-1:0] r_s2_re;
    logic signed [SAMPLE_W-1:0] r_s2_im;

    dcsa_trig_lut u_trig_lut (
        .i_phase(r_s1_phase),
        .o_trig (n_trig)
    );

    assign n_env = r_s1_zero ? '0 : (EXP_ROM[r_s1_frac] >> r_s1_shift);

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r_s2_trig <= n_trig;
            r_s2_env  <= n_env;
            r_s2_re   <= r_s1_re;
            r_s2_im   <= r_s1_im;
        end
    end

    // Stage 3: amplitude times envelope.
    logic [AMP_ENV_W-1:0]       r_s3_amp_env;
    t_trig                      r_s3_trig;
    logic signed [SAMPLE_W-1:0] r_s3_re;
    logic signed [SAMPLE_W-1:0] r_s3_im;

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_s3_amp_env <= AMP_ENV_W'(AMP_ENV_W'(cfg.amplitude) * AMP_ENV_W'(r_s2_env));
            r_s3_trig    <= r_s2_trig;
            r_s3_re      <= r_s2_re;
            r_s3_im      <= r_s2_im;
        end
    end

    // Stage 4: trig scaling with rounding on the magnitude.
    logic [PROD_W-1:0]          n_prod_re;
    logic [PROD_W-1:0]          n_prod_im;
    logic [MAG_W-1:0]           r_s4_mag_re;
    logic [MAG_W-1:0]           r_s4_mag_im;
    logic                       r_s4_neg_re;
    logic                       r_s4_neg_im;
    logic signed [SAMPLE_W-1:0] r_s4_re;
    logic signed [SAMPLE_W-1:0] r_s4_im;

    assign n_prod_re = PROD_W'(r_s3_amp_env) * PROD_W'(r_s3_trig.cmag) + (PROD_W'(1) << 29);
    assign n_prod_im = PROD_W'(r_s3_amp_env) * PROD_W'(r_s3_trig.smag) + (PROD_W'(1) << 29);

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_s4_mag_re <= n_prod_re[PROD_W-1:30];
            r_s4_mag_im <= n_prod_im[PROD_W-1:30];
            r_s4_neg_re <= r_s3_trig.cneg;
            r_s4_neg_im <= r_s3_trig.sneg;
            r_s4_re     <= r_s3_re;
            r_s4_im     <= r_s3_im;
        end
    end

    // Stage 5: sign, add to the existing sample and saturate.
    function automatic logic signed [SAMPLE_W-1:0] add_sat(
        input logic signed [SAMPLE_W-1:0] base,
        input logic                       use_base,
        input logic [MAG_W-1:0]           mag,
        input logic                       neg
    );
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] m;
        logic signed [SUM_W-1:0] s;
        b = use_base ? SUM_W'(base) : '0;
        m = neg ? -$signed(SUM_W'(mag)) : $signed(SUM_W'(mag));
        s = b + m;
        if (s[SUM_W-1:SAMPLE_W-1] == '0 || s[SUM_W-1:SAMPLE_W-1] == '1) begin
            return s[SAMPLE_W-1:0];
        end else if (s[SUM_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

    logic signed [SAMPLE_W-1:0] r_s5_re;
    logic signed [SAMPLE_W-1:0] r_s5_im;

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_s5_re <= add_sat(r_s4_re, cfg.add_mode, r_s4_mag_re, r_s4_neg_re);
            r_s5_im <= add_sat(r_s4_im, cfg.add_mode, r_s4_mag_im, r_s4_neg_im);
        end
    end

    assign o_valid    = r_v[PIPE_STAGES];
    assign o_real_out = r_s5_re;
    assign o_imag_out = r_s5_im;

endmodule

FILE: hw/rtl/dcsa_cfg_regs.sv
// Configuration register file for amplitude, phase step, decay and add mode.
module dcsa_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dcsa_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dcsa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dcsa_pkg::t_cfg                   o_cfg
);
    import dcsa_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_AMPLITUDE:  n_cfg.amplitude  = i_cfg_data[AMPLITUDE_W-1:0];
                CFG_PHASE_STEP: n_cfg.phase_step = i_cfg_data[PHASE_W-1:0];
                CFG_DECAY_LOG2: n_cfg.decay_log2 = i_cfg_data[DECAY_W-1:0];
                CFG_ADD_MODE:   n_cfg.add_mode   = i_cfg_data[0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/dcsa_trig_lut.sv
// Quarter-wave table lookup that gives cosine and sine magnitudes and signs for a phase.
module dcsa_trig_lut (
    input  logic [dcsa_pkg::PHASE_TABLE_BITS-1:0] i_phase,
    output dcsa_pkg::t_trig                       o_trig
);
    import dcsa_pkg::*;

    t_quad                 quad;
    logic [SINE_IDX_W-1:0] idx_lo;
    logic [SINE_IDX_W-1:0] idx_hi;
    logic [Q15_W-1:0]      s_lo;
    logic [Q15_W-1:0]      s_hi;

    assign quad   = t_quad'(i_phase[PHASE_TABLE_BITS-1 -: 2]);
    assign idx_lo = {1'b0, i_phase[PHASE_TABLE_BITS-3:0]};
    assign idx_hi = SINE_IDX_W'(QUARTER) - idx_lo;
    assign s_lo   = SINE_ROM[idx_lo];
    assign s_hi   = SINE_ROM[idx_hi];

    always_comb begin
        case (quad)
            QUAD_FIRST: begin
                o_trig = '{cmag: s_hi, smag: s_lo, cneg: 1'b0, sneg: 1'b0};
            end
            QUAD_SECOND: begin
                o_trig = '{cmag: s_lo, smag: s_hi, cneg: 1'b1, sneg: 1'b0};
            end
            QUAD_THIRD: begin
                o_trig = '{cmag: s_hi, smag: s_lo, cneg: 1'b1, sneg: 1'b1};
            end
            default: begin
                o_trig = '{cmag: s_lo, smag: s_hi, cneg: 1'b0, sneg: 1'b1};
            end
        endcase
    end

endmodule

FILE: hw/rtl/dcsa_checker.sv
// Port-level checker for the damped complex sinusoid adder and its bind statement.
module dcsa_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic signed [dcsa_pkg::SAMPLE_W-1:0] o_real_out,
    input logic signed [dcsa_pkg::SAMPLE_W-1:0] o_imag_out
);
    import dcsa_pkg::*;

    localparam int CNT_W = $clog2(PIPE_STAGES + 1);

    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (in_xfer && !out_xfer) begin
            n_count = r_count + CNT_W'(1);
        end else if (!in_xfer && out_xfer) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("Output valid dropped before the transfer.");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_real_out) && $stable(o_imag_out))
        else $error("Output payload changed while stalled.");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_count != '0)
        else $error("Result offered with no item in flight.");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PIPE_STAGES))
        else $error("More items in flight than pipeline stages.");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> o_ready)
        else $error("Empty pipeline refuses input.");

endmodule

bind damped_complex_sinusoid_adder dcsa_checker u_dcsa_checker (.*);

FILE: tb/sv/tb.sv
// Self-checking testbench for the damped complex sinusoid adder.
module tb;
    import dcsa_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 450;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } t_complex;

    class sample_scoreboard;
        logic [AMPLITUDE_W-1:0] amplitude;
        logic [PHASE_W-1:0]     phase_step;
        logic [DECAY_W-1:0]     decay_log2;
        logic                   add_mode;
        logic [Q15_W-1:0]       sine_tab [SINE_ENTRIES];
        logic [Q15_W-1:0]       exp_tab [EXP_ENTRIES];
        t_complex               expected_samples [$];
        int                     accepted;
        int                     errors;

        function new();
            logic [63:0] ang;
            logic [63:0] term;
            logic [63:0] acc;
            amplitude  = '0;
            phase_step = '0;
            decay_log2 = '0;
            add_mode   = 1'b0;
            accepted   = 0;
            errors     = 0;
            for (int e = 0; e < SINE_ENTRIES; e++) begin
                ang  = (64'(e) * Q30_HALF_PI) >> (PHASE_TABLE_BITS - 2);
                term = ang;
                acc  = ang;
                for (int k = 1; k <= 6; k++) begin
                    term = (term * ang) >> 30;
                    term = (term * ang) >> 30;
                    term = term / 64'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1) begin
                        acc = (acc >= term) ? acc - term : 64'd0;
                    end else begin
                        acc = acc + term;
                    end
                end
                sine_tab[e] = round_q15(acc);
            end
            for (int f = 0; f < EXP_ENTRIES; f++) begin
                ang  = (64'(f) * Q30_LN2) >> EXP_TABLE_BITS;
                term = Q30_ONE;
                acc  = Q30_ONE;
                for (int k = 1; k <= 12; k++) begin
                    term = ((term * ang) >> 30) / 64'(k);
                    if (k % 2 == 1) begin
                        acc = (acc >= term) ? acc - term : 64'd0;
                    end else begin
                        acc = acc + term;
                    end
                end
                exp_tab[f] = round_q15(acc);
            end
        endfunction

        function logic [Q15_W-1:0] round_q15(logic [63:0] v);
            logic [63:0] r;
            r = (v + 64'd16384) >> 15;
            return (r > Q15_MAX) ? Q15_W'(Q15_MAX) : r[Q15_W-1:0];
        endfunction

        function logic signed [SAMPLE_W-1:0] clip32(longint v);
            if (v > 64'sd2147483647) begin
                return 32'h7FFF_FFFF;
            end
            if (v < -64'sd2147483648) begin
                return 32'h8000_0000;
            end
            return v[SAMPLE_W-1:0];
        endfunction

        function void set_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_AMPLITUDE:  amplitude  = data[AMPLITUDE_W-1:0];
                CFG_PHASE_STEP: phase_step = data[PHASE_W-1:0];
                CFG_DECAY_LOG2: decay_log2 = data[DECAY_W-1:0];
                CFG_ADD_MODE:   add_mode   = data[0];
                default: ;
            endcase
        endfunction

        function t_complex predict_sample(logic [SAMPLE_POSITION_W-1:0] pos,
                                          logic signed [SAMPLE_W-1:0] re_in,
                                          logic signed [SAMPLE_W-1:0] im_in);
            logic [63:0]                 n;
            logic [63:0]                 phase;
            logic [63:0]                 x;
            logic [63:0]                 ipart;
            logic [63:0]                 env;
            logic [63:0]                 amp_env;
            logic [63:0]                 s_lo;
            logic [63:0]                 s_hi;
            logic [63:0]                 cmag;
            logic [63:0]                 smag;
            logic [63:0]                 mr;
            logic [63:0]                 mi;
            logic [PHASE_TABLE_BITS-1:0] ptop;
            int                          j;
            t_quad                       quad;
            logic                        cneg;
            logic                        sneg;
            longint                      sr;
            longint                      si;
            t_complex                    res;
            n     = 64'(pos[POS_W-1:0]);
            phase = (n * phase_step) & 64'hFFFF_FFFF;
            ptop  = phase[31 -: PHASE_TABLE_BITS];
            quad  = t_quad'(ptop[PHASE_TABLE_BITS-1 -: 2]);
            j     = int'(ptop[PHASE_TABLE_BITS-3:0]);
            s_lo  = 64'(sine_tab[j]);
            s_hi  = 64'(sine_tab[QUARTER - j]);
            case (quad)
                QUAD_FIRST: begin
                    cmag = s_hi; cneg = 1'b0; smag = s_lo; sneg = 1'b0;
                end
                QUAD_SECOND: begin
                    cmag = s_lo; cneg = 1'b1; smag = s_hi; sneg = 1'b0;
                end
                QUAD_THIRD: begin
                    cmag = s_hi; cneg = 1'b1; smag = s_lo; sneg = 1'b1;
                end
                default: begin
                    cmag = s_lo; cneg = 1'b0; smag = s_hi; sneg = 1'b1;
                end
            endcase
            x     = n * decay_log2;
            ipart = x >> FRAC_BITS;
            if (ipart >= 16) begin
                env = 64'd0;
            end else begin
                env = 64'(exp_tab[x[FRAC_BITS-1 -: EXP_TABLE_BITS]]) >> ipart;
            end
            amp_env = 64'(amplitude) * env;
            mr = (amp_env * cmag + 64'd536870912) >> 30;
            mi = (amp_env * smag + 64'd536870912) >> 30;
            sr = cneg ? -longint'(mr) : longint'(mr);
            si = sneg ? -longint'(mi) : longint'(mi);
            if (add_mode) begin
                sr = sr + longint'(re_in);
                si = si + longint'(im_in);
            end
            res.re = clip32(sr);
            res.im = clip32(si);
            return res;
        endfunction

        function void note_accepted_sample(logic [SAMPLE_POSITION_W-1:0] pos,
                                           logic signed [SAMPLE_W-1:0] re_in,
                                           logic signed [SAMPLE_W-1:0] im_in);
            expected_samples.push_back(predict_sample(pos, re_in, im_in));
            accepted++;
        endfunction

        function void check_output_sample(logic signed [SAMPLE_W-1:0] re,
                                          logic signed [SAMPLE_W-1:0] im);
            t_complex want;
            if (expected_samples.size() == 0) begin
                errors++;
                $display("%0t: output transfer with nothing expected, got re=%0d im=%0d",
                         $time, re, im);
                return;
            end
            want = expected_samples.pop_front();
            if (re !== want.re) begin
                errors++;
                $display("%0t: real_out expected %0d, got %0d", $time, want.re, re);
            end
            if (im !== want.im) begin
                errors++;
                $display("%0t: imag_out expected %0d, got %0d", $time, want.im, im);
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    t_cfg_reg                            i_cfg_index = CFG_AMPLITUDE;
    logic [CFG_DATA_W-1:0]               i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic [SAMPLE_POSITION_W-1:0]        i_sample_position = '0;
    logic signed [SAMPLE_W-1:0]          i_real_in = '0;
    logic signed [SAMPLE_W-1:0]          i_imag_in = '0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]          o_real_out;
    logic signed [SAMPLE_W-1:0]          o_imag_out;

    sample_scoreboard sb = new();
    bit               sender_burst = 1'b0;
    int               cycles = 0;

    damped_complex_sinusoid_adder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample_position (i_sample_position),
        .i_real_in         (i_real_in),
        .i_imag_in         (i_imag_in),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_real_out        (o_real_out),
        .o_imag_out        (o_imag_out)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_output_sample(o_real_out, o_imag_out);
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return $urandom;
        end
        if (r == 7) begin
            return 32'h7FFF_FFFF - $urandom_range(0, 40000);
        end
        if (r == 8) begin
            return 32'h8000_0000 + $urandom_range(0, 40000);
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [SAMPLE_POSITION_W-1:0] random_position();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return SAMPLE_POSITION_W'($urandom_range(0, 255));
        end
        if (r < 6) begin
            return SAMPLE_POSITION_W'($urandom_range(0, 4095));
        end
        return SAMPLE_POSITION_W'($urandom);
    endfunction

    // The receiver stalls at random and, once, holds off long enough to back up the input.
    initial begin
        int  run;
        int  stall;
        bit  held;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held && sb.accepted >= HOLD_AFTER) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(30, 150);
            i_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = idle_length();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_POSITION_W-1:0] pos,
                               input logic [SAMPLE_W-1:0] re,
                               input logic [SAMPLE_W-1:0] im);
        int gap;
        gap = sender_burst ? 0 : idle_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_sample_position <= pos;
        i_real_in         <= re;
        i_imag_in         <= im;
        do @(posedge i_clk); while (!o_ready);
        sb.note_accepted_sample(pos, re, im);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    // Unused upper bits of the narrow registers carry random values.
    task automatic load_settings(input logic [AMPLITUDE_W-1:0] amp,
                                 input logic [PHASE_W-1:0] step,
                                 input logic [DECAY_W-1:0] decay,
                                 input logic add);
        logic [CFG_DATA_W-1:0] noise;
        noise = $urandom;
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        write_reg(CFG_AMPLITUDE, {noise[31:16], amp});
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_DECAY_LOG2, decay);
        write_reg(CFG_ADD_MODE, {noise[30:0], add});
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase();
        logic [AMPLITUDE_W-1:0] amp;
        logic [PHASE_W-1:0]     step;
        logic [DECAY_W-1:0]     decay;
        int                     count;
        case ($urandom_range(0, 3))
            0: amp = '0;
            1: amp = 16'hFFFF;
            2: amp = AMPLITUDE_W'($urandom_range(1, 2000));
            default: amp = AMPLITUDE_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: step = '0;
            1: step = 32'hFFFF_FFFF;
            default: step = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0, 1: decay = '0;
            2, 3: decay = $urandom_range(1, 16);
            4, 5: decay = $urandom_range(17, 20000);
            6: decay = 32'hFFFF_FFFF;
            default: decay = $urandom;
        endcase
        load_settings(amp, step, decay, 1'($urandom_range(0, 1)));
        sender_burst = ($urandom_range(0, 3) == 0);
        count = $urandom_range(90, 130);
        repeat (count) send_sample(random_position(), random_sample(), random_sample());
        sender_burst = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Quarter-turn steps visit each quadrant; samples at the rails force saturation.
        load_settings(16'hFFFF, 32'h4000_0000, 32'h0, 1'b1);
        send_sample(16'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(16'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(16'd2, 32'h8000_0000, 32'h8000_0000);
        send_sample(16'd3, 32'h0000_0000, 32'h7FFF_FFFF);
        send_sample(16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0001);

        // Replace mode with one octave of decay per sample, up to and past the cutoff.
        load_settings(16'hFFFF, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0);
        send_sample(16'd0, $urandom, $urandom);
        send_sample(16'd1, $urandom, $urandom);
        send_sample(16'd15, $urandom, $urandom);
        send_sample(16'd16, $urandom, $urandom);
        send_sample(16'd17, $urandom, $urandom);
        send_sample(16'd255, $urandom, $urandom);
        send_sample(16'hFFFF, $urandom, $urandom);

        // Low phase and exponent bits that the tables drop.
        load_settings(16'd1000, 32'h0040_0001, 32'h0000_0101, 1'b1);
        send_sample(16'd1, random_sample(), random_sample());
        send_sample(16'd2, random_sample(), random_sample());
        send_sample(16'd255, random_sample(), random_sample());
        send_sample(16'd4095, random_sample(), random_sample());
        send_sample(16'hFFFF, random_sample(), random_sample());

        // Zero amplitude passes the input through under the steepest decay.
        load_settings(16'd0, $urandom, 32'hFFFF_FFFF, 1'b1);
        send_sample(16'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(16'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(16'hFFFF, $urandom, $urandom);

        repeat (8) run_random_phase();

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_STAGES + 5) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
